>>> rtl/ptc_pkg.sv
`timescale 1ns / 1ps
// Shared codes and constants for the power tailgate controller core.
// No dependencies; imported by the core and its checker.
package ptc_pkg;

  // Motion phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_OPEN  = 2'd1;
  localparam logic [1:0] PH_CLOSE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_UNPROG = 2'd1;
  localparam logic [1:0] ST_NARROW = 2'd2;
  localparam logic [1:0] ST_PROG   = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_NEAR_TOL   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_MARG  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STALL_TICK = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BUZZ_TICK  = 2'd3;
  localparam int unsigned CFG_DATA_W = 10;

  // Register widths and reset values
  localparam int unsigned PCT_W   = 6;
  localparam int unsigned STALL_W = 8;
  localparam int unsigned BUZZ_W  = 10;
  localparam logic [PCT_W-1:0]   NEAR_TOL_RST   = 6'd10;
  localparam logic [PCT_W-1:0]   OPEN_MARG_RST  = 6'd5;
  localparam logic [STALL_W-1:0] STALL_TICK_RST = 8'd50;
  localparam logic [BUZZ_W-1:0]  BUZZ_TICK_RST  = 10'd100;

  // Percent arithmetic: full scale is 100, held in 7 bits
  localparam int unsigned PCT_FULL_W = 7;
  localparam logic [PCT_FULL_W-1:0] PCT_FULL = 7'd100;

  // Tick counter and programming blink points (LED on at 50, off at 0 of 100)
  localparam int unsigned TICK_W = 16;
  localparam logic [6:0] BLINK_PERIOD_LAST = 7'd99;
  localparam logic [6:0] BLINK_ON_POINT    = 7'd50;

  // Stream field layout: input beat
  localparam int unsigned IN_PROG    = 0;
  localparam int unsigned IN_CLOSE   = 1;
  localparam int unsigned IN_CENTRAL = 2;
  localparam int unsigned IN_EARLY   = 3;
  localparam int unsigned IN_LATE    = 4;
  localparam int unsigned IN_POS     = 5;

  // Stream field layout: output beat
  localparam int unsigned OUT_OPEN   = 0;
  localparam int unsigned OUT_CLOSE  = 1;
  localparam int unsigned OUT_CLUTCH = 2;
  localparam int unsigned OUT_BUZZ   = 3;
  localparam int unsigned OUT_LED    = 4;
  localparam int unsigned OUT_STATUS = 5;
  localparam int unsigned OUT_PHASE  = 7;
  localparam int unsigned OUT_DATA_W = 16;

endpackage

>>> rtl/power_tailgate_controller_core.sv
`timescale 1ns / 1ps
// Power tailgate controller core: range learning, motor/clutch/buzzer drive.
// Depends on ptc_pkg.
//
// One tick beat is accepted per clock cycle, back to back, while the output side
// keeps taking results, and one result beat leaves per tick. A beat is captured
// in an input register and decided by one pass of comparisons and small
// constant-scaled products against the stored state. The result register loads
// the decision when the output side can take it and offers the result beat.
// The state update of a tick completes in the same cycle as its decision, so
// the next tick sees it without any bubble. While a result waits for the
// output side, the input register takes one more beat and then the input
// stalls until the result is taken; a stalled output holds its beat.
// Configuration writes are taken every cycle and should be done while idle.
module power_tailgate_controller_core #(
  parameter int POSITION_BITS = 10
) (
  input  logic clk,
  input  logic rst,
  // Tick beats; s_tdata from bit 0: prog_mode, close_request, central_request,
  // latched_early, latched_late, position[POSITION_BITS-1:0], zero fill
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((POSITION_BITS+5+7)/8)*8-1:0]   s_tdata,
  // Result beats; m_tdata from bit 0: motor_open, motor_close, clutch, buzzer,
  // led, status[1:0], phase[1:0], zero fill
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [ptc_pkg::OUT_DATA_W-1:0]         m_tdata,
  // Register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ptc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import ptc_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam int MW = POSITION_BITS + PCT_FULL_W;
  localparam logic [PW-1:0] MID_SCALE = PW'(1) << (PW - 1);

  // Configuration registers
  logic [PCT_W-1:0]   near_tol_pct;
  logic [PCT_W-1:0]   open_margin_pct;
  logic [STALL_W-1:0] stall_ticks;
  logic [BUZZ_W-1:0]  buzzer_ticks;

  // Input register
  logic          in_vld;
  logic          in_prog, in_close, in_central, in_early, in_late;
  logic [PW-1:0] in_pos;

  // Tick state
  logic [PW-1:0]      learned_min, learned_max, last_position;
  logic [1:0]         motion_phase;
  logic               clear_pending;
  logic [TICK_W-1:0]  tick_counter;
  logic [6:0]         tick_mod;
  logic [BUZZ_W-1:0]  buzzer_countdown;
  logic [STALL_W-1:0] stall_countdown;
  logic               pin_open, pin_close, pin_clutch, pin_buzz, pin_led;

  // Next values
  logic [PW-1:0]      learned_min_next, learned_max_next, last_position_next;
  logic [1:0]         motion_phase_next;
  logic               clear_pending_next;
  logic [TICK_W-1:0]  tick_counter_next;
  logic [6:0]         tick_mod_next;
  logic [BUZZ_W-1:0]  buzzer_countdown_next;
  logic [STALL_W-1:0] stall_countdown_next;
  logic               pin_open_next, pin_close_next, pin_clutch_next;
  logic               pin_buzz_next, pin_led_next;
  logic [1:0]         status_next;
  logic [PW-1:0]      min_base, max_base;
  logic [OUT_DATA_W-1:0] result_next;

  // Datapath products
  logic [PCT_FULL_W-1:0] keep_pct;
  logic [PW-1:0]         span;
  logic [MW-1:0]         pos_x100, keep_x_max, span_x100, tol_x100;
  logic                  near_max, sagged, too_narrow;

  logic advance;

  assign cfg_ready = 1'b1;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !in_vld || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      near_tol_pct    <= NEAR_TOL_RST;
      open_margin_pct <= OPEN_MARG_RST;
      stall_ticks     <= STALL_TICK_RST;
      buzzer_ticks    <= BUZZ_TICK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NEAR_TOL:   near_tol_pct    <= cfg_data[PCT_W-1:0];
        REG_OPEN_MARG:  open_margin_pct <= cfg_data[PCT_W-1:0];
        REG_STALL_TICK: stall_ticks     <= cfg_data[STALL_W-1:0];
        REG_BUZZ_TICK:  buzzer_ticks    <= cfg_data[BUZZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture tick beats
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_prog    <= s_tdata[IN_PROG];
      in_close   <= s_tdata[IN_CLOSE];
      in_central <= s_tdata[IN_CENTRAL];
      in_early   <= s_tdata[IN_EARLY];
      in_late    <= s_tdata[IN_LATE];
      in_pos     <= s_tdata[IN_POS +: PW];
    end
  end

  // Exact percent tests against the learned range
  assign keep_pct   = PCT_FULL - {1'b0, open_margin_pct};
  assign pos_x100   = MW'(in_pos) * MW'(PCT_FULL);
  assign keep_x_max = MW'(keep_pct) * MW'(learned_max);
  assign near_max   = pos_x100 > keep_x_max;
  assign sagged     = pos_x100 < keep_x_max;

  // Too narrow when 100*|max-min| <= max*pct
  assign span       = (learned_max >= learned_min) ? learned_max - learned_min
                                                   : learned_min - learned_max;
  assign span_x100  = MW'(span) * MW'(PCT_FULL);
  assign tol_x100   = MW'(learned_max) * MW'(near_tol_pct);
  assign too_narrow = span_x100 <= tol_x100;

  // Tick counter and its phase within the blink period
  always_comb begin
    tick_counter_next = tick_counter + TICK_W'(1);
    if (tick_counter_next == '0 || tick_mod == BLINK_PERIOD_LAST) begin
      tick_mod_next = '0;
    end else begin
      tick_mod_next = tick_mod + 7'd1;
    end
  end

  // Decide one tick
  always_comb begin
    learned_min_next      = learned_min;
    learned_max_next      = learned_max;
    last_position_next    = last_position;
    motion_phase_next     = motion_phase;
    clear_pending_next    = clear_pending;
    buzzer_countdown_next = buzzer_countdown;
    stall_countdown_next  = stall_countdown;
    pin_open_next         = pin_open;
    pin_close_next        = pin_close;
    pin_clutch_next       = pin_clutch;
    pin_buzz_next         = pin_buzz;
    pin_led_next          = pin_led;
    status_next           = ST_RUN;
    min_base              = clear_pending ? MID_SCALE : learned_min;
    max_base              = clear_pending ? MID_SCALE : learned_max;

    if (in_prog) begin
      // Learn the range; a zero bound counts as unset
      status_next        = ST_PROG;
      clear_pending_next = 1'b0;
      if (tick_mod_next == '0) begin
        pin_led_next = 1'b0;
      end else if (tick_mod_next == BLINK_ON_POINT) begin
        pin_led_next = 1'b1;
      end
      learned_min_next = (min_base == '0 || in_pos < min_base) ? in_pos : min_base;
      learned_max_next = (max_base == '0 || in_pos > max_base) ? in_pos : max_base;
    end else begin
      clear_pending_next = 1'b1;
      pin_led_next       = 1'b0;
      if (learned_min == '0 || learned_max == '0) begin
        status_next = ST_UNPROG;
      end else if (too_narrow) begin
        status_next = ST_NARROW;
      end else begin
        // Start closing on request
        if (in_close) begin
          pin_open_next     = 1'b0;
          pin_close_next    = 1'b1;
          pin_clutch_next   = 1'b1;
          motion_phase_next = PH_CLOSE;
        end
        // Central open request while latched
        if (in_central && in_early) begin
          pin_open_next     = 1'b1;
          pin_close_next    = 1'b0;
          pin_clutch_next   = 1'b1;
          pin_buzz_next     = 1'b0;
          motion_phase_next = PH_OPEN;
        end
        // Stop opening near the top
        if (motion_phase_next == PH_OPEN && near_max) begin
          motion_phase_next = PH_IDLE;
          pin_open_next     = 1'b0;
          pin_close_next    = 1'b0;
          pin_clutch_next   = 1'b0;
          pin_buzz_next     = 1'b0;
        end
        // Closing: buzzer cadence and stop rules
        if (motion_phase_next == PH_CLOSE) begin
          buzzer_countdown_next = buzzer_countdown - BUZZ_W'(1);
          if (buzzer_countdown_next == '0) begin
            pin_buzz_next         = !pin_buzz_next;
            buzzer_countdown_next = buzzer_ticks;
          end
          if (in_pos == last_position) begin
            stall_countdown_next = stall_countdown - STALL_W'(1);
          end else begin
            last_position_next   = in_pos;
            stall_countdown_next = stall_ticks;
          end
          if (in_pos < learned_min || in_late ||
              (in_pos == last_position && stall_countdown_next == '0)) begin
            pin_open_next   = 1'b0;
            pin_close_next  = 1'b0;
            pin_clutch_next = 1'b0;
            pin_buzz_next   = 1'b0;
          end
          if (in_pos == last_position && stall_countdown_next == '0) begin
            stall_countdown_next = stall_ticks;
          end
        end
        // Latched: drop everything
        if (in_late) begin
          pin_open_next     = 1'b0;
          pin_close_next    = 1'b0;
          pin_clutch_next   = 1'b0;
          pin_buzz_next     = 1'b0;
          motion_phase_next = PH_IDLE;
        end
        // Anti-fall: reopen a sagging lid
        if (motion_phase_next == PH_IDLE && !in_late && sagged) begin
          pin_open_next     = 1'b1;
          pin_close_next    = 1'b0;
          pin_clutch_next   = 1'b1;
          pin_buzz_next     = 1'b0;
          motion_phase_next = PH_OPEN;
        end
      end
    end
  end

  // Advance state on each decided tick
  always_ff @(posedge clk) begin
    if (rst) begin
      learned_min      <= '0;
      learned_max      <= '0;
      last_position    <= '0;
      motion_phase     <= PH_IDLE;
      clear_pending    <= 1'b0;
      tick_counter     <= '0;
      tick_mod         <= '0;
      buzzer_countdown <= BUZZ_TICK_RST;
      stall_countdown  <= STALL_TICK_RST;
      pin_open         <= 1'b0;
      pin_close        <= 1'b0;
      pin_clutch       <= 1'b0;
      pin_buzz         <= 1'b0;
      pin_led          <= 1'b1;
    end else if (in_vld && advance) begin
      learned_min      <= learned_min_next;
      learned_max      <= learned_max_next;
      last_position    <= last_position_next;
      motion_phase     <= motion_phase_next;
      clear_pending    <= clear_pending_next;
      tick_counter     <= tick_counter_next;
      tick_mod         <= tick_mod_next;
      buzzer_countdown <= buzzer_countdown_next;
      stall_countdown  <= stall_countdown_next;
      pin_open         <= pin_open_next;
      pin_close        <= pin_close_next;
      pin_clutch       <= pin_clutch_next;
      pin_buzz         <= pin_buzz_next;
      pin_led          <= pin_led_next;
    end
  end

  // Pack the result beat
  always_comb begin
    result_next                  = '0;
    result_next[OUT_OPEN]        = pin_open_next;
    result_next[OUT_CLOSE]       = pin_close_next;
    result_next[OUT_CLUTCH]      = pin_clutch_next;
    result_next[OUT_BUZZ]        = pin_buzz_next;
    result_next[OUT_LED]         = pin_led_next;
    result_next[OUT_STATUS +: 2] = status_next;
    result_next[OUT_PHASE +: 2]  = motion_phase_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && advance) begin
      m_tdata <= result_next;
    end
  end

endmodule

>>> rtl/ptc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the power tailgate controller core, bound to it below.
// Depends on ptc_pkg and power_tailgate_controller_core.
module ptc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tready,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [ptc_pkg::OUT_DATA_W-1:0]       m_tdata
);
  import ptc_pkg::*;

  logic [1:0] out_status;
  logic       out_open, out_close, out_clutch, out_led;

  assign out_status = m_tdata[OUT_STATUS +: 2];
  assign out_open   = m_tdata[OUT_OPEN];
  assign out_close  = m_tdata[OUT_CLOSE];
  assign out_clutch = m_tdata[OUT_CLUTCH];
  assign out_led    = m_tdata[OUT_LED];

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Never drive both motor directions
  a_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_open && out_close))
    else $error("both motor directions driven");

  // Motor drive needs the clutch engaged
  a_clutch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_open || out_close) |-> out_clutch)
    else $error("motor driven without clutch");

  // Unprogrammed or narrow range turns the indicator off
  a_led: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_status == ST_UNPROG || out_status == ST_NARROW) |-> !out_led)
    else $error("indicator on with range fault");

  // Input side is open right after reset
  a_ready: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

bind power_tailgate_controller_core ptc_checker u_ptc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
